// File: design/tre_pkg.sv
// Shared types and constants for the TCP RTT estimator.
// No dependencies; compiled before the interfaces and all modules.
package tre_pkg;

  localparam int SEQ_W   = 32;            // sequence / tick / sample width
  localparam int STATE_W = 36;            // estimator state width
  localparam int ACC_W   = STATE_W + 2;   // signed working width for the update

  localparam logic [SEQ_W-1:0] RTO_MIN_RESET = 32'd50;

  localparam int SRTT_SHIFT = 3;          // smoothed RTT kept x8
  localparam int MDEV_SHIFT = 2;          // mean deviation kept x4
  localparam int FINE_SHIFT = 3;          // extra attenuation when RTT falls
  localparam int VAR_DECAY_SHIFT = 2;

  typedef struct packed {
    logic             has_timestamp;
    logic [SEQ_W-1:0] echo_timestamp;
    logic [SEQ_W-1:0] current_time;
    logic [SEQ_W-1:0] sequence_rtt;
    logic             retrans_acked;
    logic [SEQ_W-1:0] unacked_sequence;
    logic [SEQ_W-1:0] next_sequence;
  } in_item_t;

  typedef struct packed {
    logic             valid;   // a usable sample was found
    logic [SEQ_W-1:0] value;   // never zero when valid
  } sample_t;

  typedef struct packed {
    logic [STATE_W-1:0] srtt;
    logic [STATE_W-1:0] mdev;
    logic [STATE_W-1:0] dev_peak;
    logic [STATE_W-1:0] rttvar;
    logic [SEQ_W-1:0]   epoch_seq;
  } est_state_t;

endpackage

// File: design/tre_if.sv
// Valid/ready channel interfaces: ACK events in, estimates out, config writes.
// Depends on tre_pkg for widths.
interface tre_in_if;
  logic                        valid;
  logic                        ready;
  logic                        has_timestamp;
  logic [tre_pkg::SEQ_W-1:0]   echo_timestamp;
  logic [tre_pkg::SEQ_W-1:0]   current_time;
  logic signed [tre_pkg::SEQ_W-1:0] sequence_rtt;
  logic                        retrans_acked;
  logic [tre_pkg::SEQ_W-1:0]   unacked_sequence;
  logic [tre_pkg::SEQ_W-1:0]   next_sequence;

  modport source (output valid, has_timestamp, echo_timestamp, current_time, sequence_rtt,
                  retrans_acked, unacked_sequence, next_sequence, input ready);
  modport sink   (input valid, has_timestamp, echo_timestamp, current_time, sequence_rtt,
                  retrans_acked, unacked_sequence, next_sequence, output ready);
endinterface

interface tre_out_if;
  logic                        valid;
  logic                        ready;
  logic                        sample_used;
  logic [tre_pkg::STATE_W-1:0] smoothed_rtt_x8;
  logic [tre_pkg::STATE_W-1:0] mean_deviation_x4;
  logic [tre_pkg::STATE_W-1:0] rtt_variance;

  modport source (output valid, sample_used, smoothed_rtt_x8, mean_deviation_x4,
                  rtt_variance, input ready);
  modport sink   (input valid, sample_used, smoothed_rtt_x8, mean_deviation_x4,
                  rtt_variance, output ready);
endinterface

interface tre_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [tre_pkg::SEQ_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: design/tcp_rtt_estimator_top.sv
// TCP RTT estimator top level (Jacobson/Karels with Karn's rule).
// Path: input register, then result register; an item waits in the input register while
// the result register is held by back-pressure.
// Throughput: one ACK event per cycle while results are taken; state update is combinational.
// Reset (rst_n low, synchronous): state cleared to zero, rto_minimum back to 50, no items held.
// Depends on tre_pkg, tre_if, tre_sample_sel and tre_estimate.
module tcp_rtt_estimator_top (
  input  logic         clk,
  input  logic         rst_n,
  tre_in_if.sink       in_if,
  tre_out_if.source    out_if,
  tre_cfg_if.sink      cfg_if
);
  import tre_pkg::*;

  // input stage
  in_item_t   in_r;
  logic       in_v_r;
  logic       adv;          // input stage moves into the result register

  // estimator state and config
  est_state_t st_r, st_nxt;
  logic [SEQ_W-1:0] rto_min_r;

  // result register
  logic               out_v_r;
  logic               used_r;
  logic [STATE_W-1:0] srtt_out_r, mdev_out_r, var_out_r;

  sample_t smp;

  // Result register frees up when empty or taken this cycle; input stage
  // then refills in the same cycle, so items stream at one per clock while results are taken.
  assign adv          = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready  = !in_v_r || adv;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid             = out_v_r;
  assign out_if.sample_used       = used_r;
  assign out_if.smoothed_rtt_x8   = srtt_out_r;
  assign out_if.mean_deviation_x4 = mdev_out_r;
  assign out_if.rtt_variance      = var_out_r;

  tre_sample_sel u_sel (
    .item (in_r),
    .smp  (smp)
  );

  tre_estimate u_est (
    .cur       (st_r),
    .smp       (smp),
    .una       (in_r.unacked_sequence),
    .nxt       (in_r.next_sequence),
    .rto_min   (rto_min_r),
    .nxt_state (st_nxt)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      st_r      <= '0;
      rto_min_r <= RTO_MIN_RESET;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_if.valid) begin
        rto_min_r <= cfg_if.data;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_r.has_timestamp    <= in_if.has_timestamp;
      in_r.echo_timestamp   <= in_if.echo_timestamp;
      in_r.current_time     <= in_if.current_time;
      in_r.sequence_rtt     <= in_if.sequence_rtt;
      in_r.retrans_acked    <= in_if.retrans_acked;
      in_r.unacked_sequence <= in_if.unacked_sequence;
      in_r.next_sequence    <= in_if.next_sequence;
    end
    if (adv) begin
      used_r     <= smp.valid;
      srtt_out_r <= st_nxt.srtt;
      mdev_out_r <= st_nxt.mdev;
      var_out_r  <= st_nxt.rttvar;
    end
  end

  // held input item must not be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !adv) |-> !in_if.ready)
    else $error("input stage accepted while holding an item");

  // event without a usable sample leaves the estimator untouched
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !smp.valid) |=> $stable(st_r))
    else $error("state changed without a sample");

  // any used sample leaves a nonzero smoothed RTT
  a_srtt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && smp.valid) |=> (st_r.srtt != '0))
    else $error("smoothed RTT zero after update");

  // result reports the state just written
  a_out_matches: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_v_r && (srtt_out_r == st_r.srtt) && (var_out_r == st_r.rttvar)))
    else $error("result does not match estimator state");

endmodule

// File: design/tre_sample_sel.sv
// RTT sample selection: timestamp echo first, then sequence timing (Karn's rule).
// Depends on tre_pkg.
module tre_sample_sel (
  input  tre_pkg::in_item_t item,
  output tre_pkg::sample_t  smp
);
  import tre_pkg::*;

  logic             ts_ok;
  logic             seq_ok;
  logic [SEQ_W-1:0] ts_diff;
  logic [SEQ_W-1:0] raw;

  always_comb begin
    ts_ok   = item.has_timestamp && (item.echo_timestamp != '0);
    seq_ok  = !item.sequence_rtt[SEQ_W-1] && !item.retrans_acked;
    ts_diff = item.current_time - item.echo_timestamp;   // wraps mod 2^32
    raw     = ts_ok ? ts_diff : item.sequence_rtt;
    smp.valid = ts_ok || seq_ok;
    // zero sample counts as one tick
    smp.value = (raw == '0) ? {{(SEQ_W-1){1'b0}}, 1'b1} : raw;
  end

endmodule

// File: design/tre_estimate.sv
// Jacobson/Karels state update for one sample: srtt, mdev, max deviation, variance.
// Depends on tre_pkg; purely combinational.
module tre_estimate (
  input  tre_pkg::est_state_t       cur,
  input  tre_pkg::sample_t          smp,
  input  logic [tre_pkg::SEQ_W-1:0] una,
  input  logic [tre_pkg::SEQ_W-1:0] nxt,
  input  logic [tre_pkg::SEQ_W-1:0] rto_min,
  output tre_pkg::est_state_t       nxt_state
);
  import tre_pkg::*;

  logic signed [ACC_W-1:0] m, s, d, m1, s_new, mag, mag_adj, adj, d_new;
  logic [STATE_W-1:0] mdev_upd, max_upd, var_upd, rto_ext, init_mdev;
  logic [SEQ_W-1:0]   epoch_diff;

  always_comb begin
    m  = {{(ACC_W-SEQ_W){1'b0}}, smp.value};
    s  = {{(ACC_W-STATE_W){1'b0}}, cur.srtt};
    d  = {{(ACC_W-STATE_W){1'b0}}, cur.mdev};
    m1 = m - (s >>> SRTT_SHIFT);
    s_new = s + m1;
    // RTT fell: use the magnitude, shrink the positive part further
    mag = -m1 - (d >>> MDEV_SHIFT);
    mag_adj = (!mag[ACC_W-1] && (mag != '0)) ? (mag >>> FINE_SHIFT) : mag;
    adj = m1[ACC_W-1] ? mag_adj : (m1 - (d >>> MDEV_SHIFT));
    d_new = d + adj;

    rto_ext  = {{(STATE_W-SEQ_W){1'b0}}, rto_min};
    mdev_upd = d_new[STATE_W-1:0];
    max_upd  = cur.dev_peak;
    var_upd  = cur.rttvar;
    if (mdev_upd > max_upd) begin
      max_upd = mdev_upd;
      if (max_upd > var_upd) begin
        var_upd = max_upd;
      end
    end

    // serial-number compare: una is past the recorded epoch
    epoch_diff = cur.epoch_seq - una;

    init_mdev = {{(STATE_W-SEQ_W-1){1'b0}}, smp.value, 1'b0};

    nxt_state = cur;
    if (smp.valid) begin
      if (cur.srtt != '0) begin
        nxt_state.srtt     = s_new[STATE_W-1:0];
        nxt_state.mdev     = mdev_upd;
        nxt_state.dev_peak = max_upd;
        nxt_state.rttvar   = var_upd;
        if (epoch_diff[SEQ_W-1]) begin
          if (max_upd < var_upd) begin
            nxt_state.rttvar = var_upd - ((var_upd - max_upd) >> VAR_DECAY_SHIFT);
          end
          nxt_state.epoch_seq = nxt;
          nxt_state.dev_peak  = rto_ext;
        end
      end else begin
        nxt_state.srtt      = {{(STATE_W-SEQ_W-SRTT_SHIFT){1'b0}}, smp.value,
                               {SRTT_SHIFT{1'b0}}};
        nxt_state.mdev      = init_mdev;
        nxt_state.dev_peak  = (init_mdev > rto_ext) ? init_mdev : rto_ext;
        nxt_state.rttvar    = nxt_state.dev_peak;
        nxt_state.epoch_seq = nxt;
      end
    end
  end

endmodule
